>>> hdl/first_fit_heap_allocator_macros.svh
// Assertion macros for the first-fit heap allocator checker.
// Used by hdl/ffha_checker.sv; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFHA_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFHA_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEAP_BYTES_DEF   = 65536;
   localparam int HEADER_BYTES_DEF = 32;

   localparam logic [16:0] LIMIT_RESET = 17'h10000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OOM      = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [15:0] off;
      logic [16:0] size;
      logic        used;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_A_RD, S_A_CHK, S_A_FIT, S_SHU_RD, S_SHU_WR, S_SPL_W1, S_SPL_W2,
      S_A_APP, S_F_RD, S_F_CHK, S_F_PRV, S_F_NXT, S_F_MRG, S_SHD_RD, S_SHD_WR,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_START, OP_RD_PTR, OP_SRCH_NEXT, OP_FOUND, OP_FIT_WHOLE,
      OP_SPLIT_BEGIN, OP_SHU_RD, OP_SHU_WR, OP_SPLIT_W1, OP_SPLIT_W2, OP_APPEND,
      OP_BAD, OP_SAVE_PREV, OP_SAVE_NEXT, OP_MERGE, OP_SHD_RD, OP_SHD_WR,
      OP_DELIVER
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic at_end;
      logic hit_alloc;
      logic hit_free;
      logic has_prev;
      logic split_ok;
      logic shu_done;
      logic merge_shift;
      logic shd_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> hdl/ffha_datapath.sv
// Datapath: block table memory, pointers, heap registers and result word.
// Depends on ffha_pkg; driven by ffha_controller commands.
`timescale 1ns / 1ps
`default_nettype none

module ffha_datapath #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ffha_pkg::cmd_type cmd,
   output ffha_pkg::stat_type     stat,
   input  wire logic              req_action,
   input  wire logic [16:0]       req_request_bytes,
   input  wire logic [15:0]       req_block_address,
   input  wire logic              csr_valid,
   input  wire logic [16:0]       csr_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [15:0]            rsp_address,
   output logic [1:0]             rsp_status
);

   localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
   localparam logic [15:0] H16 = 16'(HEADER_BYTES);
   localparam logic [16:0] H17 = 17'(HEADER_BYTES);
   localparam logic [17:0] H18 = 18'(HEADER_BYTES);
   localparam logic [18:0] H19 = 19'(HEADER_BYTES);
   localparam logic [16:0] CAP = (HEAP_BYTES > 131071) ? 17'h1FFFF : 17'(HEAP_BYTES);

   ffha_pkg::entry_type mem [MAX_BLOCKS];
   ffha_pkg::entry_type rdata_ff, cur_ff, prev_ff, next_ff;
   ffha_pkg::entry_type wdata;
   logic                we;
   logic [CW-1:0]       waddr, raddr;

   logic [CW-1:0] ptr_ff, ptr_in, idx_ff, idx_in, count_ff, count_in;
   logic [16:0]   top_ff, top_in, limit_ff;
   logic          action_ff;
   logic [17:0]   need_ff;
   logic [15:0]   baddr_ff;
   logic          pf_ff, pf_in, nf_ff, nf_in;
   logic [1:0]    m_ff, m_in;
   logic [15:0]   res_addr_ff, res_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_address_ff;
   logic [1:0]    rsp_status_ff;

   logic [17:0]   need_new;
   logic [CW-1:0] j;
   logic [15:0]   jo;
   logic [16:0]   base_sz, msz;
   logic [1:0]    m;
   logic          last;
   logic [16:0]   eff_limit;
   logic [18:0]   app_end;
   logic          app_ok;

   assign need_new  = ({1'b0, req_request_bytes} + 18'd7) & ~18'd7;
   assign eff_limit = (limit_ff > CAP) ? CAP : limit_ff;
   assign app_end   = {2'b0, top_ff} + H19 + {1'b0, need_ff};
   assign app_ok    = (count_ff < MAXC) && (app_end <= {2'b0, eff_limit}) &&
                      (({1'b0, top_ff} + H18) <= 18'h0FFFF);

   assign j       = pf_ff ? idx_ff - CW'(1) : idx_ff;
   assign jo      = pf_ff ? prev_ff.off : cur_ff.off;
   assign base_sz = pf_ff ? prev_ff.size + H17 + cur_ff.size : cur_ff.size;
   assign msz     = base_sz + (nf_ff ? H17 + next_ff.size : 17'd0);
   assign m       = {1'b0, pf_ff} + {1'b0, nf_ff};
   assign last    = (j + CW'(1) + CW'(m)) == count_ff;

   always_comb begin
      stat.is_free     = action_ff;
      stat.at_end      = ptr_ff == count_ff;
      stat.hit_alloc   = !rdata_ff.used && ({1'b0, rdata_ff.size} >= need_ff);
      stat.hit_free    = rdata_ff.used && (({1'b0, rdata_ff.off} + H17) == {1'b0, baddr_ff});
      stat.has_prev    = ptr_ff != '0;
      stat.split_ok    = ({2'b0, cur_ff.size} >= ({1'b0, need_ff} + H19 + 19'd8)) &&
                         (count_ff < MAXC);
      stat.shu_done    = ptr_ff == idx_ff + CW'(1);
      stat.merge_shift = !last && (m != 2'd0);
      stat.shd_done    = ptr_ff == count_ff;
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      case (cmd.op)
         ffha_pkg::OP_FOUND:     raddr = stat.has_prev ? ptr_ff - CW'(1) : ptr_ff + CW'(1);
         ffha_pkg::OP_SAVE_PREV: raddr = idx_ff + CW'(1);
         ffha_pkg::OP_SHU_RD:    raddr = ptr_ff - CW'(1);
         ffha_pkg::OP_SHD_RD:    raddr = ptr_ff + CW'(m_ff);
         default:                raddr = ptr_ff;
      endcase
   end

   always_comb begin
      we            = 1'b0;
      waddr         = ptr_ff;
      wdata         = rdata_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      pf_in         = pf_ff;
      nf_in         = nf_ff;
      m_in          = m_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      case (cmd.op)
         ffha_pkg::OP_START: begin
            ptr_in = '0;
         end
         ffha_pkg::OP_SRCH_NEXT: begin
            ptr_in = ptr_ff + CW'(1);
         end
         ffha_pkg::OP_FOUND: begin
            idx_in = ptr_ff;
            pf_in  = 1'b0;
            nf_in  = 1'b0;
         end
         ffha_pkg::OP_FIT_WHOLE: begin
            we            = 1'b1;
            waddr         = idx_ff;
            wdata         = '{off: cur_ff.off, size: cur_ff.size, used: 1'b1};
            res_addr_in   = cur_ff.off + H16;
            res_status_in = ffha_pkg::ST_OK;
         end
         ffha_pkg::OP_SPLIT_BEGIN: begin
            ptr_in = count_ff;
         end
         ffha_pkg::OP_SHU_WR: begin
            we     = 1'b1;
            waddr  = ptr_ff;
            ptr_in = ptr_ff - CW'(1);
         end
         ffha_pkg::OP_SPLIT_W1: begin
            we    = 1'b1;
            waddr = idx_ff + CW'(1);
            wdata = '{off: cur_ff.off + H16 + need_ff[15:0],
                      size: cur_ff.size - need_ff[16:0] - H17, used: 1'b0};
         end
         ffha_pkg::OP_SPLIT_W2: begin
            we            = 1'b1;
            waddr         = idx_ff;
            wdata         = '{off: cur_ff.off, size: need_ff[16:0], used: 1'b1};
            count_in      = count_ff + CW'(1);
            res_addr_in   = cur_ff.off + H16;
            res_status_in = ffha_pkg::ST_OK;
         end
         ffha_pkg::OP_APPEND: begin
            if (app_ok) begin
               we            = 1'b1;
               waddr         = count_ff;
               wdata         = '{off: top_ff[15:0], size: need_ff[16:0], used: 1'b1};
               count_in      = count_ff + CW'(1);
               top_in        = app_end[16:0];
               res_addr_in   = top_ff[15:0] + H16;
               res_status_in = ffha_pkg::ST_OK;
            end else begin
               res_addr_in   = '0;
               res_status_in = ffha_pkg::ST_OOM;
            end
         end
         ffha_pkg::OP_BAD: begin
            res_addr_in   = '0;
            res_status_in = ffha_pkg::ST_BAD_FREE;
         end
         ffha_pkg::OP_SAVE_PREV: begin
            pf_in = !rdata_ff.used;
         end
         ffha_pkg::OP_SAVE_NEXT: begin
            nf_in = (idx_ff + CW'(1) < count_ff) && !rdata_ff.used;
         end
         ffha_pkg::OP_MERGE: begin
            res_addr_in   = '0;
            res_status_in = ffha_pkg::ST_OK;
            if (last) begin
               top_in   = {1'b0, jo};
               count_in = j;
            end else begin
               we       = 1'b1;
               waddr    = j;
               wdata    = '{off: jo, size: msz, used: 1'b0};
               count_in = count_ff - CW'(m);
               ptr_in   = j + CW'(1);
               m_in     = m;
            end
         end
         ffha_pkg::OP_SHD_WR: begin
            we     = 1'b1;
            waddr  = ptr_ff;
            ptr_in = ptr_ff + CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr[IDXW-1:0]] <= wdata;
      end
      rdata_ff <= mem[raddr[IDXW-1:0]];
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      idx_ff        <= idx_in;
      pf_ff         <= pf_in;
      nf_ff         <= nf_in;
      m_ff          <= m_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (cmd.op == ffha_pkg::OP_START) begin
         action_ff <= req_action;
         need_ff   <= need_new;
         baddr_ff  <= req_block_address;
      end
      if (cmd.op == ffha_pkg::OP_FOUND) begin
         cur_ff <= rdata_ff;
      end
      if (cmd.op == ffha_pkg::OP_SAVE_PREV) begin
         prev_ff <= rdata_ff;
      end
      if (cmd.op == ffha_pkg::OP_SAVE_NEXT) begin
         next_ff <= rdata_ff;
      end
      if (cmd.op == ffha_pkg::OP_DELIVER) begin
         rsp_address_ff <= res_addr_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= ffha_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         top_ff   <= top_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.op == ffha_pkg::OP_DELIVER) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

>>> hdl/ffha_controller.sv
// Controller: sequences search, split, append, merge and table shifts.
// Depends on ffha_pkg; commands ffha_datapath.
`timescale 1ns / 1ps
`default_nettype none

module ffha_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_action,
   input  wire ffha_pkg::stat_type stat,
   output ffha_pkg::cmd_type       cmd,
   output logic                    req_stall
);

   ffha_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffha_pkg::S_IDLE:   if (req_valid) begin
            state_in = req_action ? ffha_pkg::S_F_RD : ffha_pkg::S_A_RD;
         end
         ffha_pkg::S_A_RD:   state_in = stat.at_end ? ffha_pkg::S_A_APP : ffha_pkg::S_A_CHK;
         ffha_pkg::S_A_CHK:  state_in = stat.hit_alloc ? ffha_pkg::S_A_FIT : ffha_pkg::S_A_RD;
         ffha_pkg::S_A_FIT:  state_in = stat.split_ok ? ffha_pkg::S_SHU_RD : ffha_pkg::S_DONE;
         ffha_pkg::S_SHU_RD: state_in = stat.shu_done ? ffha_pkg::S_SPL_W1 : ffha_pkg::S_SHU_WR;
         ffha_pkg::S_SHU_WR: state_in = ffha_pkg::S_SHU_RD;
         ffha_pkg::S_SPL_W1: state_in = ffha_pkg::S_SPL_W2;
         ffha_pkg::S_SPL_W2: state_in = ffha_pkg::S_DONE;
         ffha_pkg::S_A_APP:  state_in = ffha_pkg::S_DONE;
         ffha_pkg::S_F_RD:   state_in = stat.at_end ? ffha_pkg::S_DONE : ffha_pkg::S_F_CHK;
         ffha_pkg::S_F_CHK: begin
            if (!stat.hit_free) begin
               state_in = ffha_pkg::S_F_RD;
            end else begin
               state_in = stat.has_prev ? ffha_pkg::S_F_PRV : ffha_pkg::S_F_NXT;
            end
         end
         ffha_pkg::S_F_PRV:  state_in = ffha_pkg::S_F_NXT;
         ffha_pkg::S_F_NXT:  state_in = ffha_pkg::S_F_MRG;
         ffha_pkg::S_F_MRG:  state_in = stat.merge_shift ? ffha_pkg::S_SHD_RD : ffha_pkg::S_DONE;
         ffha_pkg::S_SHD_RD: state_in = stat.shd_done ? ffha_pkg::S_DONE : ffha_pkg::S_SHD_WR;
         ffha_pkg::S_SHD_WR: state_in = ffha_pkg::S_SHD_RD;
         ffha_pkg::S_DONE:   if (stat.out_free) begin
            state_in = ffha_pkg::S_IDLE;
         end
         default:            state_in = ffha_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = ffha_pkg::OP_NONE;
      case (state_ff)
         ffha_pkg::S_IDLE:   if (req_valid) cmd.op = ffha_pkg::OP_START;
         ffha_pkg::S_A_RD:   if (!stat.at_end) cmd.op = ffha_pkg::OP_RD_PTR;
         ffha_pkg::S_A_CHK:
            cmd.op = stat.hit_alloc ? ffha_pkg::OP_FOUND : ffha_pkg::OP_SRCH_NEXT;
         ffha_pkg::S_A_FIT:
            cmd.op = stat.split_ok ? ffha_pkg::OP_SPLIT_BEGIN : ffha_pkg::OP_FIT_WHOLE;
         ffha_pkg::S_SHU_RD: if (!stat.shu_done) cmd.op = ffha_pkg::OP_SHU_RD;
         ffha_pkg::S_SHU_WR: cmd.op = ffha_pkg::OP_SHU_WR;
         ffha_pkg::S_SPL_W1: cmd.op = ffha_pkg::OP_SPLIT_W1;
         ffha_pkg::S_SPL_W2: cmd.op = ffha_pkg::OP_SPLIT_W2;
         ffha_pkg::S_A_APP:  cmd.op = ffha_pkg::OP_APPEND;
         ffha_pkg::S_F_RD:
            cmd.op = stat.at_end ? ffha_pkg::OP_BAD : ffha_pkg::OP_RD_PTR;
         ffha_pkg::S_F_CHK:
            cmd.op = stat.hit_free ? ffha_pkg::OP_FOUND : ffha_pkg::OP_SRCH_NEXT;
         ffha_pkg::S_F_PRV:  cmd.op = ffha_pkg::OP_SAVE_PREV;
         ffha_pkg::S_F_NXT:  cmd.op = ffha_pkg::OP_SAVE_NEXT;
         ffha_pkg::S_F_MRG:  cmd.op = ffha_pkg::OP_MERGE;
         ffha_pkg::S_SHD_RD: if (!stat.shd_done) cmd.op = ffha_pkg::OP_SHD_RD;
         ffha_pkg::S_SHD_WR: cmd.op = ffha_pkg::OP_SHD_WR;
         ffha_pkg::S_DONE:   if (stat.out_free) cmd.op = ffha_pkg::OP_DELIVER;
         default:            cmd.op = ffha_pkg::OP_NONE;
      endcase
   end

   assign req_stall = state_ff != ffha_pkg::S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_controller and ffha_datapath.
//
//   channel  ports                                         flow
//   req      req_valid/req_stall, action, bytes, address   in
//   rsp      rsp_valid/rsp_stall, address, status          out
//   csr      csr_valid/csr_ready, csr_data (heap_limit)    in
//
// One request at a time through a table memory with one write port and a
// registered read port: each entry searched takes a read and a check state,
// each entry shifted a read and a write state, then the result is delivered.
// Synchronous reset empties the table at once; no clearing pass.
// A result word waits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [16:0] req_request_bytes,
   input  wire logic [15:0] req_block_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_address,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [16:0] csr_data
);

   ffha_pkg::cmd_type  cmd;
   ffha_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ffha_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   ffha_datapath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_request_bytes (req_request_bytes),
      .req_block_address (req_block_address),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_address       (rsp_address),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire

>>> hdl/ffha_checker.sv
// Port-level checker for first_fit_heap_allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_address,
   input wire logic [1:0]  rsp_status
);

   `FFHA_CHECK(a_status_code, rsp_valid, rsp_status <= ffha_pkg::ST_BAD_FREE,
               "undefined status code")
   `FFHA_CHECK(a_fail_zero, rsp_valid && rsp_status != ffha_pkg::ST_OK,
               rsp_address == 16'd0, "failed word carries an address")
   `FFHA_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
                    "second word taken while busy")
   `FFHA_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_address) && $stable(rsp_status),
                    "stalled result changed")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

`default_nettype wire

>>> tb/first_fit_heap_allocator_tb.sv
// Self-checking testbench for the first-fit heap allocator: mirrors the block
// table in a scoreboard class and checks every result word. Needs ffha_pkg.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

   localparam int NBLK = 64;
   localparam int HDR = 32;
   localparam int HEAP = 65536;
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE = 1'b1;
   localparam int WATCHDOG_LIMIT = 20000;

   class heap_scoreboard;
      int unsigned blk_off[NBLK];
      int unsigned blk_size[NBLK];
      bit blk_used[NBLK];
      int unsigned blk_count;
      int unsigned top;
      int unsigned limit_reg;
      logic [15:0] want_addr[$];
      logic [1:0] want_status[$];
      int errors;
      int n_ok, n_oom, n_bad;

      function new();
         blk_count = 0;
         top = 0;
         limit_reg = 32'h10000;
         errors = 0;
      endfunction

      function void open_slot(int unsigned pos);
         for (int unsigned k = blk_count; k > pos; k--) begin
            blk_off[k] = blk_off[k-1];
            blk_size[k] = blk_size[k-1];
            blk_used[k] = blk_used[k-1];
         end
         blk_count++;
      endfunction

      function void close_slot(int unsigned pos);
         for (int unsigned k = pos; k + 1 < blk_count; k++) begin
            blk_off[k] = blk_off[k+1];
            blk_size[k] = blk_size[k+1];
            blk_used[k] = blk_used[k+1];
         end
         blk_count--;
      endfunction

      function void allocate(int unsigned req, output logic [15:0] a, output logic [1:0] s);
         int unsigned need, lim, base;
         need = (req + 7) & ~32'd7;
         lim = (limit_reg < HEAP) ? limit_reg : HEAP;
         for (int unsigned i = 0; i < blk_count; i++) begin
            if (!blk_used[i] && blk_size[i] >= need) begin
               if (blk_size[i] >= need + HDR + 8 && blk_count < NBLK) begin
                  open_slot(i + 1);
                  blk_off[i+1] = blk_off[i] + HDR + need;
                  blk_size[i+1] = blk_size[i] - need - HDR;
                  blk_used[i+1] = 0;
                  blk_size[i] = need;
               end
               blk_used[i] = 1;
               a = 16'(blk_off[i] + HDR);
               s = ffha_pkg::ST_OK;
               return;
            end
         end
         base = top;
         if (blk_count >= NBLK || base + HDR + need > lim || base + HDR > 16'hFFFF) begin
            a = '0;
            s = ffha_pkg::ST_OOM;
            return;
         end
         blk_off[blk_count] = base;
         blk_size[blk_count] = need;
         blk_used[blk_count] = 1;
         blk_count++;
         top = base + HDR + need;
         a = 16'(base + HDR);
         s = ffha_pkg::ST_OK;
      endfunction

      function logic [1:0] release_block(int unsigned addr);
         int i;
         i = -1;
         for (int unsigned k = 0; k < blk_count; k++)
            if (i < 0 && blk_used[k] && blk_off[k] + HDR == addr) i = k;
         if (i < 0) return ffha_pkg::ST_BAD_FREE;
         blk_used[i] = 0;
         if (i > 0 && !blk_used[i-1]) begin
            blk_size[i-1] += HDR + blk_size[i];
            close_slot(i);
            i--;
         end
         if (i + 1 < blk_count && !blk_used[i+1]) begin
            blk_size[i] += HDR + blk_size[i+1];
            close_slot(i + 1);
         end
         if (i + 1 == blk_count) begin
            top = blk_off[i];
            close_slot(i);
         end
         return ffha_pkg::ST_OK;
      endfunction

      function void note_request(logic act, logic [16:0] nbytes, logic [15:0] addr);
         logic [15:0] a;
         logic [1:0] s;
         a = '0;
         if (act == ACT_ALLOC) allocate(nbytes, a, s);
         else s = release_block(addr);
         if (s == ffha_pkg::ST_OK) n_ok++;
         else if (s == ffha_pkg::ST_OOM) n_oom++;
         else n_bad++;
         want_addr.push_back(a);
         want_status.push_back(s);
      endfunction

      function void check_result(logic [15:0] a, logic [1:0] s);
         logic [15:0] ea;
         logic [1:0] es;
         if (want_addr.size() == 0) begin
            $error("unexpected result word: address %0d status %0d", a, s);
            errors++;
            return;
         end
         ea = want_addr.pop_front();
         es = want_status.pop_front();
         if (a !== ea) begin
            $error("address: expected %0d, actual %0d", ea, a);
            errors++;
         end
         if (s !== es) begin
            $error("status: expected %0d, actual %0d", es, s);
            errors++;
         end
      endfunction

      // pick a live payload address, or 0 if none
      function int unsigned live_address();
         int unsigned cnt, pick;
         cnt = 0;
         for (int unsigned k = 0; k < blk_count; k++) if (blk_used[k]) cnt++;
         if (cnt == 0) return 0;
         pick = $urandom_range(cnt - 1);
         for (int unsigned k = 0; k < blk_count; k++)
            if (blk_used[k]) begin
               if (pick == 0) return blk_off[k] + HDR;
               pick--;
            end
         return 0;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [16:0] req_request_bytes = '0;
   logic [15:0] req_block_address = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_address;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [16:0] csr_data = '0;

   heap_scoreboard heap_sb = new();
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit long_hold = 1'b0;
   int items_sent = 0;

   first_fit_heap_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_request_bytes(req_request_bytes), .req_block_address(req_block_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_address(rsp_address),
      .rsp_status(rsp_status), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // monitor: note accepted words, check results, run the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            heap_sb.note_request(req_action, req_request_bytes, req_block_address);
         if (rsp_valid && !rsp_stall) heap_sb.check_result(rsp_address, rsp_status);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog timeout");
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int mode;
      mode = $urandom_range(99);
      if (long_hold) rsp_stall <= 1'b1;
      else if (hold_rsp) rsp_stall <= 1'b0;
      else if (mode < 25) rsp_stall <= 1'b1;
      else rsp_stall <= 1'b0;
   end

   task automatic send_word(logic act, logic [16:0] nbytes, logic [15:0] addr);
      req_valid <= 1'b1;
      req_action <= act;
      req_request_bytes <= nbytes;
      req_block_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      hold_rsp = 1'b1;
      @(posedge clock);
      while (heap_sb.want_addr.size() != 0) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   task automatic write_limit(logic [16:0] value);
      drain();
      repeat (300) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      heap_sb.limit_reg = value;
   endtask

   // random word: mostly live frees and modest allocs, some noise
   task automatic random_word();
      int r;
      logic [16:0] nbytes;
      r = $urandom_range(99);
      if (r < 45) begin
         if ($urandom_range(9) == 0) nbytes = 17'($urandom);
         else nbytes = 17'($urandom_range(600));
         send_word(ACT_ALLOC, nbytes, 16'($urandom));
      end else if (r < 88) begin
         send_word(ACT_FREE, 17'($urandom), 16'(heap_sb.live_address()));
      end else begin
         send_word(ACT_FREE, 17'($urandom), 16'($urandom));
      end
   endtask

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && count > 0) begin
            random_word();
            burst--;
            count--;
         end
         if (count > 0 && $urandom_range(3) != 0) begin
            go_idle();
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      go_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, extremes, split, merge, bad frees, first block free
      send_word(ACT_ALLOC, 17'd0, 16'd0);
      send_word(ACT_ALLOC, 17'd1, 16'hFFFF);
      send_word(ACT_ALLOC, 17'd100, 16'd0);
      send_word(ACT_ALLOC, 17'd8, 16'd0);
      send_word(ACT_FREE, 17'h1FFFF, 16'd32);
      send_word(ACT_FREE, 17'd0, 16'd32);
      send_word(ACT_FREE, 17'd0, 16'd104);
      send_word(ACT_ALLOC, 17'd16, 16'd0);
      send_word(ACT_FREE, 17'd0, 16'hFFFF);
      send_word(ACT_FREE, 17'd0, 16'd0);
      send_word(ACT_ALLOC, 17'h1FFFF, 16'd0);
      send_word(ACT_ALLOC, 17'd65536, 16'd0);
      send_word(ACT_ALLOC, 17'd60000, 16'd0);
      send_word(ACT_ALLOC, 17'd8000, 16'd0);
      for (int k = 0; k < 70; k++) send_word(ACT_ALLOC, 17'd0, 16'd0);
      go_idle();
      drain();
      while (heap_sb.live_address() != 0)
         send_word(ACT_FREE, 17'd0, 16'(heap_sb.live_address()));
      go_idle();

      write_limit(17'd0);
      send_word(ACT_ALLOC, 17'd0, 16'd0);
      go_idle();
      write_limit(17'd200);
      random_phase(60);
      write_limit(17'h1FFFF);
      send_word(ACT_ALLOC, 17'd65400, 16'd0);
      send_word(ACT_ALLOC, 17'd200, 16'd0);

      // long receiver hold while offering words, then pause until drained
      long_hold = 1'b1;
      fork
         begin
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         random_phase(20);
      join
      drain();

      write_limit(17'd4096);
      random_phase(250);
      write_limit(17'd65536);
      random_phase(250);
      write_limit(17'd1500);
      random_phase(200);

      drain();
      repeat (300) @(posedge clock);
      $display("sent %0d request words: %0d ok, %0d out of memory, %0d bad free",
               items_sent, heap_sb.n_ok, heap_sb.n_oom, heap_sb.n_bad);
      $display("covered limits 0, 200, 1500, 4096, 65536 and over range");
      if (heap_sb.errors == 0 && heap_sb.want_addr.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_datapath.sv
hdl/ffha_controller.sv
hdl/first_fit_heap_allocator.sv
hdl/ffha_checker.sv
tb/first_fit_heap_allocator_tb.sv
